// ===== hdl/etb_pkg.sv =====
// Shared types and constants for the elimination tree builder.
// No dependencies.
package etb_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int NODE_W      = 10;
   localparam int ADDR_W      = $clog2(MAX_COLUMNS);
   localparam int ANC_W       = NODE_W + 1;
   localparam int STEP_W      = $clog2(MAX_COLUMNS) + 1;

   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_ENTRY = 1'b1;

   // Bit NODE_W set: node has no ancestor yet
   localparam logic [ANC_W-1:0] NO_ANCESTOR = ANC_W'(1) << NODE_W;

   typedef struct packed {
      logic              operation;
      logic [NODE_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] child;
      logic [NODE_W-1:0] parent;
   } rsp_type;

   function automatic logic node_in_range(input logic [NODE_W-1:0] node);
      return (32'(node) < MAX_COLUMNS);
   endfunction

endpackage

// ===== hdl/elimination_tree_builder.sv =====
// Elimination tree builder, top level.
// Depends on etb_pkg and etb_ram.
//
// Builds the elimination tree of a symmetric sparse matrix, column by column.
// req channel (valid/ready): operation OP_BEGIN selects index as the current
// column and marks it as having no ancestor; operation OP_ENTRY gives a
// nonzero row of the current column. Rows at or above the column, and any
// index at or beyond MAX_COLUMNS, are dropped. The host sends a begin for every
// column before any row names it.
// rsp channel (valid/ready): one transfer (child, parent) each time a row's
// ancestor walk reaches a node with no ancestor; parent is the current column.
// Roots are never reported.
// A begin or a dropped entry is handled in the cycle it is taken. An entry
// that walks visits each node on the walk, the row included: the ancestor
// store is one RAM read and one write per cycle, and each visit needs the
// previous read's data. Path compression keeps walks short on average.
// A result sits in an output register; the next item is taken while it waits.
// If the receiver stalls and a walk finds another result, the walk holds on
// that node until the output register frees.
// Reset clears the control state and current column; the ancestor store
// needs no clearing since every entry is written by a begin before use.
module elimination_tree_builder
   import etb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic              state_ff, state_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] row_ff, row_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              fwd_ff, fwd_in;
   logic [ANC_W-1:0]  fwd_data_ff, fwd_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Ancestor store port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ANC_W-1:0]  wr_data, rd_data;

   logic              req_xfer;
   logic [ANC_W-1:0]  anc;
   logic [NODE_W-1:0] anc_node;
   logic              out_free;

   etb_ram #(
      .DEPTH(MAX_COLUMNS),
      .WIDTH(ANC_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Same-cycle read of the entry being written returns the new value
   assign anc      = fwd_ff ? fwd_data_ff : rd_data;
   assign anc_node = anc[NODE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      row_in       = row_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(row_ff);
      wr_data      = ANC_W'(cur_ff);
      rd_en        = 1'b0;
      rd_addr      = ADDR_W'(req.index);

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && node_in_range(req.index)) begin
               if (req.operation == OP_BEGIN) begin
                  cur_in  = req.index;
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(req.index);
                  wr_data = NO_ANCESTOR;
               end else if (req.index < cur_ff) begin
                  // start the walk at this row
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(req.index);
                  row_in   = req.index;
                  steps_in = '0;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (anc[NODE_W]) begin
               // reached a node with no ancestor: its parent is the column
               if (out_free) begin
                  wr_en        = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in.child  = row_ff;
                  rsp_in.parent = cur_ff;
                  state_in     = S_IDLE;
               end
            end else begin
               wr_en = 1'b1;
               if (anc_node < cur_ff && node_in_range(anc_node) &&
                   (32'(steps_ff) + 1 < MAX_COLUMNS)) begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(anc_node);
                  row_in   = anc_node;
                  steps_in = steps_ff + STEP_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (rd_en) begin
         fwd_in      = wr_en && (wr_addr == rd_addr);
         fwd_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      steps_ff    <= steps_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/etb_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module etb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/etb_checker.sv =====
// Port-level checks for the elimination tree builder, bound to the top level.
// Depends on etb_pkg and elimination_tree_builder.
module etb_assertions
   import etb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp changed while stalled");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // A child is always a lower node than its parent column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.child < rsp.parent)
      else $error("child not below parent");

   // A begin taken with no result pending makes no result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req.operation == OP_BEGIN && !rsp_valid |=> !rsp_valid)
      else $error("result after begin");

endmodule

bind elimination_tree_builder etb_assertions u_etb_assertions (.*);
